@@ rtl/assert_macros.svh @@
// Assertion macros used by the deframer parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked while out of reset.
`define WSD_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked while out of reset.
`define WSD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define WSD_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define WSD_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

@@ rtl/wsd_pkg.sv @@
// Types, codes and helpers shared by the deframer modules.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_MSG_BYTE  = 3'd1,
    KIND_EMPTY_END = 3'd2,
    KIND_CTRL_BYTE = 3'd3,
    KIND_CTRL_END  = 3'd4,
    KIND_TOO_BIG   = 3'd5
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        last;
    logic [15:0] status;
  } res_t;

  localparam logic [3:0]  OP_CONT  = 4'd0;
  localparam logic [3:0]  OP_CLOSE = 4'd8;
  localparam logic [3:0]  OP_PONG  = 4'd10;

  localparam logic [6:0]  LEN_EXT16 = 7'd126;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;
  localparam logic [3:0]  EXT16_BYTES = 4'd2;
  localparam logic [3:0]  EXT64_BYTES = 4'd8;

  localparam logic [15:0] STATUS_NORMAL  = 16'd1000;
  localparam logic [15:0] STATUS_TOO_BIG = 16'd1009;
  localparam logic [31:0] MAX_MSG_RESET  = 32'd10485760;

  // Close, ping and pong are control frames.
  function automatic logic is_ctrl(input logic [3:0] op);
    return (op >= OP_CLOSE) && (op <= OP_PONG);
  endfunction

endpackage

@@ rtl/wsd_in_stage.sv @@
// Input register: holds one received byte until the parser takes it.
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;
endmodule

@@ rtl/wsd_parser.sv @@
// Frame parser: header fields, length, mask key, unmasking and result build.
`include "assert_macros.svh"
module wsd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  logic [31:0] max_r;
  phase_t      phase_r, phase_nxt;
  logic        final_r, final_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [63:0] pl_r, pl_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic [31:0] frag_r, frag_nxt;
  logic [3:0]  msg_op_r, msg_op_nxt;
  logic [15:0] status_r, status_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        closed_r, closed_nxt;

  logic [63:0] pl_hdr;
  logic        len_done;
  logic        go_payload;
  logic        too_big;
  logic [3:0]  msg_op_eff;
  logic [7:0]  key_byte;
  logic [7:0]  ub;
  logic        pl_last;

  // Accumulated fragment length plus this frame against the limit, no overflow.
  assign too_big  = ({33'd0, frag_r} + {1'b0, pl_hdr}) > {33'd0, max_r};
  assign key_byte = masked_r ? key_r[{~midx_r, 3'b000} +: 8] : 8'h00;
  assign ub       = rx_byte ^ key_byte;
  assign pl_last  = (pl_r == 64'd1);
  assign msg_op_eff = (opcode_r != OP_CONT) ? opcode_r : msg_op_r;

  always_comb begin
    phase_nxt    = phase_r;
    final_nxt    = final_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    len_left_nxt = len_left_r;
    pl_nxt       = pl_r;
    key_nxt      = key_r;
    midx_nxt     = midx_r;
    frag_nxt     = frag_r;
    msg_op_nxt   = msg_op_r;
    status_nxt   = status_r;
    seen_nxt     = seen_r;
    closed_nxt   = closed_r;
    pl_hdr       = pl_r;
    len_done     = 1'b0;
    go_payload   = 1'b0;
    res          = '0;
    res.kind     = KIND_NONE;

    if (step && !closed_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          final_nxt  = rx_byte[7];
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          if (rx_byte[6:0] == LEN_EXT16) begin
            pl_nxt       = '0;
            len_left_nxt = EXT16_BYTES;
            phase_nxt    = PH_EXTLEN;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            pl_nxt       = '0;
            len_left_nxt = EXT64_BYTES;
            phase_nxt    = PH_EXTLEN;
          end else begin
            pl_hdr   = {57'd0, rx_byte[6:0]};
            pl_nxt   = pl_hdr;
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          pl_hdr = {pl_r[55:0], rx_byte};
          pl_nxt = pl_hdr;
          if (len_left_r != 4'd0) begin
            len_left_nxt = len_left_r - 4'd1;
          end
          len_done = (len_left_nxt == 4'd0);
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], rx_byte};
          midx_nxt = midx_r + 2'd1;
          go_payload = (midx_nxt == 2'd0);
        end
        PH_PAYLOAD: begin
          if (pl_r == 64'd0) begin
            phase_nxt = PH_HDR0;
          end else begin
            midx_nxt = midx_r + 2'd1;
            pl_nxt   = pl_r - 64'd1;
            res.valid = 1'b1;
            res.data  = ub;
            if (is_ctrl(opcode_r)) begin
              if (opcode_r == OP_CLOSE) begin
                if (seen_r == 2'd0) begin
                  if (pl_r >= 64'd2) begin
                    status_nxt = {ub, 8'h00};
                  end
                  seen_nxt = 2'd1;
                end else if (seen_r == 2'd1) begin
                  status_nxt = status_r | {8'h00, ub};
                  seen_nxt   = 2'd2;
                end
              end
              res.kind   = KIND_CTRL_BYTE;
              res.opcode = opcode_r;
              res.last   = pl_last;
              if (pl_last) begin
                phase_nxt = PH_HDR0;
                if (opcode_r == OP_CLOSE) begin
                  closed_nxt = 1'b1;
                  res.status = status_nxt;
                end
              end
            end else begin
              res.kind   = KIND_MSG_BYTE;
              res.opcode = msg_op_r;
              res.last   = pl_last && final_r;
              if (pl_last) begin
                phase_nxt = PH_HDR0;
                if (final_r) begin
                  msg_op_nxt = OP_CONT;
                end
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // Length known: fetch the mask key or start the payload.
      if (len_done) begin
        if (masked_nxt) begin
          midx_nxt  = 2'd0;
          key_nxt   = '0;
          phase_nxt = PH_MASK;
        end else begin
          go_payload = 1'b1;
        end
      end

      // Header complete: decide what the frame means.
      if (go_payload) begin
        phase_nxt = PH_PAYLOAD;
        if (is_ctrl(opcode_r)) begin
          if (opcode_r == OP_CLOSE) begin
            status_nxt = STATUS_NORMAL;
            seen_nxt   = 2'd0;
          end
          if (pl_hdr == 64'd0) begin
            phase_nxt  = PH_HDR0;
            res.valid  = 1'b1;
            res.kind   = KIND_CTRL_END;
            res.opcode = opcode_r;
            res.last   = 1'b1;
            if (opcode_r == OP_CLOSE) begin
              closed_nxt = 1'b1;
              res.status = STATUS_NORMAL;
            end
          end
        end else begin
          msg_op_nxt = msg_op_eff;
          if (!final_r) begin
            if (too_big) begin
              closed_nxt = 1'b1;
              phase_nxt  = PH_HDR0;
              res.valid  = 1'b1;
              res.kind   = KIND_TOO_BIG;
              res.opcode = msg_op_eff;
              res.status = STATUS_TOO_BIG;
            end else begin
              frag_nxt = frag_r + pl_hdr[31:0];
              if (pl_hdr == 64'd0) begin
                phase_nxt = PH_HDR0;
              end
            end
          end else begin
            frag_nxt = '0;
            if (pl_hdr == 64'd0) begin
              phase_nxt  = PH_HDR0;
              msg_op_nxt = OP_CONT;
              res.valid  = 1'b1;
              res.kind   = KIND_EMPTY_END;
              res.opcode = msg_op_eff;
              res.last   = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= MAX_MSG_RESET;
      phase_r    <= PH_HDR0;
      final_r    <= 1'b0;
      opcode_r   <= OP_CONT;
      masked_r   <= 1'b0;
      len_left_r <= '0;
      pl_r       <= '0;
      key_r      <= '0;
      midx_r     <= '0;
      frag_r     <= '0;
      msg_op_r   <= OP_CONT;
      status_r   <= STATUS_NORMAL;
      seen_r     <= '0;
      closed_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      phase_r    <= phase_nxt;
      final_r    <= final_nxt;
      opcode_r   <= opcode_nxt;
      masked_r   <= masked_nxt;
      len_left_r <= len_left_nxt;
      pl_r       <= pl_nxt;
      key_r      <= key_nxt;
      midx_r     <= midx_nxt;
      frag_r     <= frag_nxt;
      msg_op_r   <= msg_op_nxt;
      status_r   <= status_nxt;
      seen_r     <= seen_nxt;
      closed_r   <= closed_nxt;
    end
  end

  `WSD_ASSERT_NEXT(a_closed_sticks, clk, rst_n, closed_r, closed_r)
  `WSD_ASSERT_IMP(a_closed_silent, clk, rst_n, closed_r, !res.valid)
  `WSD_ASSERT_NEXT(a_too_big_closes, clk, rst_n, step && res.valid && (res.kind == KIND_TOO_BIG), closed_r)
  `WSD_ASSERT_IMP(a_end_to_header, clk, rst_n, step && res.valid && (res.kind == KIND_CTRL_END || res.kind == KIND_EMPTY_END), phase_nxt == PH_HDR0)
endmodule

@@ rtl/wsd_out_stage.sv @@
// Result register: holds one result until the receiver takes it.
module wsd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  wsd_pkg::res_t res,
  input  logic          out_stall,
  output logic          out_free,
  output wsd_pkg::res_t res_q
);
  import wsd_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;
  logic load;

  assign out_free = !valid_r || !out_stall;
  assign load     = out_free && step && res.valid;

  always_comb begin
    if (out_free) begin
      valid_nxt = load;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  always_comb begin
    res_q       = res_r;
    res_q.valid = valid_r;
  end
endmodule

@@ rtl/websocket_frame_deframer.sv @@
// Top level of the streaming WebSocket frame deframer.
//
// Usage: received bytes enter on in_valid/in_rx_byte; an item is taken at a
// clock edge where in_valid is high and in_stall is low. Each byte advances
// the header parser (FIN/opcode, length, optional 16/64-bit extension,
// optional mask key) or is unmasked as a payload byte. Results leave on
// out_valid with kind, data_byte, msg_opcode, msg_last and close_status and
// are taken where out_valid is high and out_stall is low. Header bytes give
// no result, except an end item for some empty frames and the too-big error
// item; payload bytes give one each. A result passes the input register,
// then the result register, before out_valid rises. Throughput: one byte per
// cycle while out_stall is low, set by the single parser step.
// Stall: while the result register holds an item and out_stall is high, the
// parser holds and in_stall rises once the input register is full too.
// Reset (rst_n low, synchronous): both registers empty, parser back to the
// first header byte, size limit back to 10485760. cfg_wr_en writes the limit;
// write it only while the block is idle. After a close frame or a too-big
// error every further byte is dropped until reset.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_msg_opcode,
  output logic        out_msg_last,
  output logic [15:0] out_close_status
);
  import wsd_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       out_free;
  logic       step;
  res_t       res;
  res_t       res_q;

  // Advance the parser whenever a byte waits and the result slot can take it.
  assign step = byte_valid && out_free;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (byte_data),
    .res         (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .res_q     (res_q)
  );

  // Drive the result ports from the result register.
  assign out_valid        = res_q.valid;
  assign out_kind         = res_q.kind;
  assign out_data_byte    = res_q.data;
  assign out_msg_opcode   = res_q.opcode;
  assign out_msg_last     = res_q.last;
  assign out_close_status = res_q.status;
endmodule

@@ dv/deframe_compare.sv @@
// Deframer result predictor and comparator: mirrors the parser per accepted byte.
module deframe_compare (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_stall,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [3:0]  out_msg_opcode,
  input  logic        out_msg_last,
  input  logic [15:0] out_close_status,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_checked
);
  import wsd_pkg::*;

  // Parser copy, updated once per accepted byte.
  phase_t      phase;
  logic        fin_q;
  logic [3:0]  frame_op;
  logic        masked_q;
  logic [3:0]  len_bytes_left;
  logic [63:0] bytes_left;
  logic [31:0] mask_word;
  logic [1:0]  key_idx;
  logic [31:0] frag_total;
  logic [3:0]  msg_op;
  logic [15:0] status;
  logic [1:0]  status_seen;
  logic        closed;
  logic [31:0] size_limit;

  res_t expected_results[$];

  function automatic res_t make_result(input kind_t k, input logic [7:0] d,
                                       input logic [3:0] op, input logic l,
                                       input logic [15:0] st);
    res_t r;
    r.valid  = 1'b1;
    r.kind   = k;
    r.data   = d;
    r.opcode = op;
    r.last   = l;
    r.status = st;
    return r;
  endfunction

  // Header done: decide what the frame means before its payload.
  function automatic res_t open_payload();
    logic [3:0] op;
    phase = PH_PAYLOAD;
    if (frame_op >= OP_CLOSE && frame_op <= OP_PONG) begin
      if (frame_op == OP_CLOSE) begin
        status      = STATUS_NORMAL;
        status_seen = 2'd0;
      end
      if (bytes_left == 64'd0) begin
        phase = PH_HDR0;
        if (frame_op == OP_CLOSE) begin
          closed = 1'b1;
          return make_result(KIND_CTRL_END, 8'h00, frame_op, 1'b1, status);
        end
        return make_result(KIND_CTRL_END, 8'h00, frame_op, 1'b1, 16'd0);
      end
      return '0;
    end
    if (frame_op != OP_CONT) msg_op = frame_op;
    if (!fin_q) begin
      if (frag_total > size_limit || bytes_left > {32'd0, size_limit - frag_total}) begin
        closed = 1'b1;
        phase  = PH_HDR0;
        return make_result(KIND_TOO_BIG, 8'h00, msg_op, 1'b0, STATUS_TOO_BIG);
      end
      frag_total = frag_total + bytes_left[31:0];
      if (bytes_left == 64'd0) phase = PH_HDR0;
      return '0;
    end
    frag_total = 32'd0;
    if (bytes_left == 64'd0) begin
      op     = msg_op;
      msg_op = OP_CONT;
      phase  = PH_HDR0;
      return make_result(KIND_EMPTY_END, 8'h00, op, 1'b1, 16'd0);
    end
    return '0;
  endfunction

  function automatic res_t finish_length();
    if (masked_q) begin
      key_idx   = 2'd0;
      mask_word = 32'd0;
      phase     = PH_MASK;
      return '0;
    end
    return open_payload();
  endfunction

  // Advance the parser copy by one byte; valid is set when a result is due.
  function automatic res_t deframe_byte(input logic [7:0] b);
    logic [7:0]  mask_byte;
    logic [7:0]  plain;
    logic        last;
    logic [15:0] st;
    logic [3:0]  op;
    if (closed) return '0;
    case (phase)
      PH_HDR0: begin
        fin_q    = b[7];
        frame_op = b[3:0];
        phase    = PH_HDR1;
      end
      PH_HDR1: begin
        masked_q   = b[7];
        bytes_left = 64'd0;
        if (b[6:0] == LEN_EXT16) begin
          len_bytes_left = EXT16_BYTES;
          phase          = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          len_bytes_left = EXT64_BYTES;
          phase          = PH_EXTLEN;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          return finish_length();
        end
      end
      PH_EXTLEN: begin
        bytes_left = {bytes_left[55:0], b};
        if (len_bytes_left != 4'd0) len_bytes_left = len_bytes_left - 4'd1;
        if (len_bytes_left == 4'd0) return finish_length();
      end
      PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        key_idx   = key_idx + 2'd1;
        if (key_idx == 2'd0) return open_payload();
      end
      PH_PAYLOAD: begin
        if (bytes_left == 64'd0) begin
          phase = PH_HDR0;
        end else begin
          mask_byte = masked_q ? mask_word[8 * (3 - key_idx) +: 8] : 8'h00;
          key_idx   = key_idx + 2'd1;
          plain     = b ^ mask_byte;
          last      = (bytes_left == 64'd1);
          if (frame_op >= OP_CLOSE && frame_op <= OP_PONG) begin
            st = 16'd0;
            if (frame_op == OP_CLOSE) begin
              if (status_seen == 2'd0) begin
                if (bytes_left >= 64'd2) status = {plain, 8'h00};
                status_seen = 2'd1;
              end else if (status_seen == 2'd1) begin
                status      = status | {8'h00, plain};
                status_seen = 2'd2;
              end
            end
            bytes_left = bytes_left - 64'd1;
            if (last) begin
              phase = PH_HDR0;
              if (frame_op == OP_CLOSE) begin
                closed = 1'b1;
                st     = status;
              end
            end
            return make_result(KIND_CTRL_BYTE, plain, frame_op, last, st);
          end
          bytes_left = bytes_left - 64'd1;
          op         = msg_op;
          if (last) begin
            phase = PH_HDR0;
            if (fin_q) msg_op = OP_CONT;
          end
          return make_result(KIND_MSG_BYTE, plain, op, last && fin_q, 16'd0);
        end
      end
      default: phase = PH_HDR0;
    endcase
    return '0;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches = mismatches + 1;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : sample
    res_t want;
    res_t got;
    if (!rst_n) begin
      phase          = PH_HDR0;
      fin_q          = 1'b0;
      frame_op       = OP_CONT;
      masked_q       = 1'b0;
      len_bytes_left = 4'd0;
      bytes_left     = 64'd0;
      mask_word      = 32'd0;
      key_idx        = 2'd0;
      frag_total     = 32'd0;
      msg_op         = OP_CONT;
      status         = STATUS_NORMAL;
      status_seen    = 2'd0;
      closed         = 1'b0;
      size_limit     = MAX_MSG_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) size_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          $error("unexpected result: kind %0d, data_byte %0d", out_kind, out_data_byte);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", {13'd0, want.kind}, {13'd0, out_kind});
          check_field("data_byte", {8'd0, want.data}, {8'd0, out_data_byte});
          check_field("msg_opcode", {12'd0, want.opcode}, {12'd0, out_msg_opcode});
          check_field("msg_last", {15'd0, want.last}, {15'd0, out_msg_last});
          check_field("close_status", want.status, out_close_status);
          results_checked = results_checked + 1;
        end
      end
      if (in_valid && !in_stall) begin
        got = deframe_byte(in_rx_byte);
        if (got.valid) expected_results.push_back(got);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ dv/tb_websocket_frame_deframer.sv @@
// Stimulus and verdict for the streaming WebSocket frame deframer.
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_BYTES  = 440;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [3:0]  out_msg_opcode;
  logic        out_msg_last;
  logic [15:0] out_close_status;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;

  // Stimulus bookkeeping: what the generator knows about the link.
  bit              idle_on = 1'b1;
  int unsigned     bytes_sent = 0;
  int unsigned     limit_writes = 0;
  logic [31:0]     limit_now = MAX_MSG_RESET;
  longint unsigned frag_acc = 0;
  int unsigned     stall_left = 0;
  int unsigned     quiet = 0;

  always #5 clk = ~clk;

  websocket_frame_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_rx_byte       (in_rx_byte),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_msg_opcode   (out_msg_opcode),
    .out_msg_last     (out_msg_last),
    .out_close_status (out_close_status)
  );

  deframe_compare u_compare (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_rx_byte       (in_rx_byte),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_msg_opcode   (out_msg_opcode),
    .out_msg_last     (out_msg_last),
    .out_close_status (out_close_status),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked)
  );

  // Receiver backpressure: random stall bursts while idling is enabled; a burst
  // in progress runs to its end.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] hdr0(input logic fin, input logic [2:0] rsv,
                                      input logic [3:0] op);
    return {fin, rsv, op};
  endfunction

  // Mostly short payloads, now and then a medium or extended one.
  function automatic longint unsigned pick_len(input longint unsigned cap);
    longint unsigned n;
    int unsigned r;
    r = $urandom_range(0, 63);
    if (r == 0) n = $urandom_range(126, 300);
    else if (r < 5) n = $urandom_range(13, 125);
    else n = $urandom_range(0, 12);
    if (n > cap) n = cap;
    return n;
  endfunction

  // Text and binary most of the time, reserved opcodes otherwise, which the parser treats as data.
  function automatic logic [3:0] data_opcode();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 4) return OP_TEXT;
    if (r < 6) return OP_BINARY;
    if (r == 6) return 4'($urandom_range(3, 7));
    return 4'($urandom_range(11, 15));
  endfunction

  // Offer one item and hold it until the block takes it. An optional gap with
  // valid low goes in front of the item.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every predicted result has left the block,
  // then keep waiting for header bytes still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = value;
    limit_writes++;
  endtask

  // One frame on the wire: header with random reserved bits, a length in
  // 7-bit, 16-bit or 64-bit form, an optional mask key, then body bytes.
  // The declared length and the number of body bytes sent may differ.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                            input int unsigned body, input logic masked);
    int unsigned form;
    int unsigned r;
    r = $urandom_range(0, 15);
    if (len > 64'd65535) form = 2;
    else if (len > 64'd125) form = (r < 4) ? 2 : 1;
    else form = (r == 0) ? 2 : (r < 3) ? 1 : 0;
    send_byte(hdr0(fin, 3'($urandom), op));
    if (form == 0) begin
      send_byte({masked, len[6:0]});
    end else if (form == 1) begin
      send_byte({masked, LEN_EXT16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, LEN_EXT64});
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom));
    repeat (body) send_byte(8'($urandom));
  endtask

  // Data frame that keeps the fragment total within the current limit, so no
  // size error occurs until the run wants one.
  task automatic send_data_frame(input logic fin, input logic [3:0] op,
                                 input longint unsigned len);
    longint unsigned room;
    room = longint'(limit_now) - frag_acc;
    if (!fin) begin
      if (len > room) len = room;
      frag_acc += len;
    end else begin
      frag_acc = 0;
    end
    send_frame(fin, op, len, int'(len), 1'($urandom));
  endtask

  // Ping or pong, sometimes without FIN, sometimes longer than 125 bytes.
  task automatic send_control();
    longint unsigned len;
    len = pick_len(300);
    send_frame($urandom_range(0, 7) != 0, $urandom_range(0, 1) ? OP_PING : OP_PONG,
               len, int'(len), 1'($urandom));
  endtask

  // A well-formed message: one frame, or a fragment chain with control
  // frames slipped in between fragments.
  task automatic send_message();
    logic [3:0] op;
    int unsigned frags;
    op    = data_opcode();
    frags = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 5);
    for (int f = 0; f < frags; f++) begin
      if (f != 0 && $urandom_range(0, 3) == 0) send_control();
      send_data_frame(f == frags - 1, (f == 0) ? op : OP_CONT,
                      pick_len((f == frags - 1) ? 300 : 40));
    end
  endtask

  // Random traffic for one limit setting. Mostly well-formed messages; the
  // rest are ping/pong frames, stray continuations, interrupted fragment chains and random
  // frames (never close, which would end the link). With calm_tail set, the
  // last stretch runs without any idling. Always finish on a final frame so
  // the fragment total is back at zero for the next limit.
  task automatic run_traffic(input int unsigned budget, input bit calm_tail);
    int unsigned start;
    int unsigned pick;
    logic [3:0] op;
    longint unsigned len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if (calm_tail && bytes_sent - start + 250 >= budget) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 15);
      if (pick <= 10) begin
        send_message();
      end else if (pick <= 12) begin
        send_control();
      end else if (pick == 13) begin
        send_data_frame(1'($urandom), OP_CONT, pick_len(40));
      end else if (pick == 14) begin
        send_data_frame(1'($urandom), data_opcode(), pick_len(40));
      end else begin
        op  = 4'($urandom_range(0, 15));
        len = pick_len(20);
        if (op == OP_CLOSE) op = OP_CONT;
        if (is_ctrl(op)) send_frame(1'($urandom), op, len, int'(len), 1'($urandom));
        else send_data_frame(1'($urandom), op, len);
      end
    end
    send_data_frame(1'b1, OP_CONT, pick_len(12));
  endtask

  // Shut the link one of several ways, then feed bytes that must be dropped
  // (or, for the endless frame, streamed as payload).
  task automatic end_link(output string how);
    int unsigned v;
    int unsigned n;
    longint unsigned a;
    v = $urandom_range(0, 6);
    case (v)
      0: begin
        how = "an empty close frame";
        send_frame(1'b1, OP_CLOSE, 64'd0, 0, 1'($urandom));
      end
      1: begin
        how = "a one-byte close frame";
        send_frame(1'b1, OP_CLOSE, 64'd1, 1, 1'($urandom));
      end
      2: begin
        how = "a close frame with status";
        n = $urandom_range(2, 6);
        send_frame(1'b1, OP_CLOSE, 64'(n), n, 1'($urandom));
      end
      3: begin
        how = "an oversized close frame";
        n = $urandom_range(126, 140);
        send_frame(1'b1, OP_CLOSE, 64'(n), n, 1'($urandom));
      end
      4: begin
        // Shrink the limit, then let a fragment chain run past it.
        how = "a fragment chain over the size limit";
        write_limit($urandom_range(0, 20));
        a = $urandom_range(0, int'(limit_now));
        send_data_frame(1'b0, OP_BINARY, a);
        send_frame(1'b0, OP_CONT, 64'(longint'(limit_now) - a + 1 + $urandom_range(0, 4)),
                   0, 1'($urandom));
      end
      5: begin
        how = "a fragment with a 64-bit length, top bit set";
        send_frame(1'b0, data_opcode(), {1'b1, 31'($urandom), 32'($urandom)}, 0,
                   1'($urandom));
      end
      default: begin
        how = "an endless final frame";
        send_frame(1'b1, OP_BINARY, {1'b1, 31'($urandom), 32'($urandom)}, 150,
                   1'($urandom));
      end
    endcase
    repeat (16) send_byte(8'($urandom));
  endtask

  initial begin : stimulus
    int unsigned directed_bytes;
    string how;

    // Hold reset, then release it for good.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: one-byte text, empty binary, a fragment chain with an
    // empty middle fragment, an empty ping without FIN and an empty final
    // continuation, a one-byte pong, and a masked 16-bit length frame with
    // reserved bits set. Payload bytes hit both 0x00 and 0xFF.
    send_byte(hdr0(1'b1, 3'b000, OP_TEXT));
    send_byte({1'b0, 7'd1});
    send_byte(8'h00);
    send_byte(hdr0(1'b1, 3'b000, OP_BINARY));
    send_byte({1'b0, 7'd0});
    send_byte(hdr0(1'b0, 3'b000, OP_TEXT));
    send_byte({1'b0, 7'd1});
    send_byte(8'hFF);
    send_byte(hdr0(1'b0, 3'b000, OP_CONT));
    send_byte({1'b0, 7'd0});
    send_byte(hdr0(1'b0, 3'b000, OP_PING));
    send_byte({1'b0, 7'd0});
    send_byte(hdr0(1'b1, 3'b000, OP_CONT));
    send_byte({1'b0, 7'd0});
    send_byte(hdr0(1'b1, 3'b000, OP_PONG));
    send_byte({1'b0, 7'd1});
    send_byte(8'h5A);
    send_byte(hdr0(1'b1, 3'b111, OP_BINARY));
    send_byte({1'b1, LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h3C);
    directed_bytes = bytes_sent;

    // Random traffic under the reset limit, the largest limit, a small
    // random limit, and a zero limit (only empty fragments pass).
    run_traffic(PHASE_BYTES, 1'b0);
    write_limit(32'hFFFF_FFFF);
    run_traffic(PHASE_BYTES, 1'b0);
    write_limit($urandom_range(16, 400));
    run_traffic(PHASE_BYTES, 1'b0);
    write_limit(32'd0);
    run_traffic(PHASE_BYTES, 1'b1);

    idle_on = 1'b0;
    end_link(how);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Drove %0d bytes (%0d directed) over %0d size-limit writes; closed with %s.",
             bytes_sent, directed_bytes, limit_writes, how);
    $display("Compared %0d results field by field.", results_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
